FILE: rtl/core/rc4_variant_challenge_base64_core_macros.svh
// Assertion helpers shared by the core modules.
// Each module that uses them has clk and rst_n in scope.
`ifndef RC4_VARIANT_CHALLENGE_BASE64_CORE_MACROS_SVH
`define RC4_VARIANT_CHALLENGE_BASE64_CORE_MACROS_SVH

// Same-cycle implication
`define RVC_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication
`define RVC_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/core/rc4vc_pkg.sv
package rc4vc_pkg;

    // Key register
    localparam int KEY_W     = 48;
    localparam int KEY_EXT_W = 64;
    localparam logic [KEY_W-1:0] KEY_RESET = 48'h396333453679;

    // Challenge framing
    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_LAST = 5'd19;
    localparam int CHARS_PER_GROUP = 4;
    localparam int CHAR_W = 7;

    // What an encrypted byte does to the base64 packer
    typedef enum logic [1:0] {
        KIND_HOLD  = 2'd0,
        KIND_GROUP = 2'd1,
        KIND_FINAL = 2'd2
    } kind_t;

    // Classified challenge byte, front to engine
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        kind_t      kind;
    } item_t;

    // Encrypted byte, engine to packer
    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
    } enc_t;

    // Engine sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_INIT,
        ST_KS_RI,
        ST_KS_RJ,
        ST_KS_WI,
        ST_KS_WJ,
        ST_RA,
        ST_RB,
        ST_WA,
        ST_WB,
        ST_RK,
        ST_HAND
    } eng_state_t;

    // ASCII code points used by the alphabet
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'd43;
    localparam logic [CHAR_W-1:0] CH_SLASH = 7'd47;
    localparam logic [CHAR_W-1:0] CH_UPPER = 7'd65;
    localparam logic [CHAR_W-1:0] CH_LOWER_OFS = 7'd71;  // 'a' - 26
    localparam logic [CHAR_W-1:0] CH_DIGIT_OFS = 7'd4;   // 52 - '0'

    // Base64 alphabet lookup
    function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] s);
        logic [CHAR_W-1:0] w;
        w = {1'b0, s};
        if (s < 6'd26)
            return CH_UPPER + w;
        else if (s < 6'd52)
            return w + CH_LOWER_OFS;
        else if (s < 6'd62)
            return w - CH_DIGIT_OFS;
        else if (s == 6'd62)
            return CH_PLUS;
        else
            return CH_SLASH;
    endfunction

endpackage

FILE: rtl/core/rc4vc_front.sv
`include "rc4_variant_challenge_base64_core_macros.svh"

module rc4vc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          challenge_byte,
    output logic                q_valid,
    output rc4vc_pkg::item_t    q_item,
    input  logic                q_pop
);
    import rc4vc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       ph_reg, ph_next;
    item_t            q_mem [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push;
    item_t            cls;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_mem[rd_ptr_reg];

    // Classify by position in the challenge
    always_comb
    begin
        cls.data  = challenge_byte;
        cls.first = (pos_reg == '0);
        if (pos_reg == POS_LAST)
            cls.kind = KIND_FINAL;
        else if (ph_reg == 2'd2)
            cls.kind = KIND_GROUP;
        else
            cls.kind = KIND_HOLD;
    end

    // Position and group phase advance
    always_comb
    begin
        if (pos_reg == POS_LAST)
        begin
            pos_next = '0;
            ph_next  = 2'd0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
            ph_next  = (ph_reg == 2'd2) ? 2'd0 : ph_reg + 1'b1;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !q_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!push && q_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            ph_reg     <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                pos_reg    <= pos_next;
                ph_reg     <= ph_next;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    // Two-entry queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= cls;
    end

    `RVC_ASSERT_IMP(a_pos_range, 1'b1, pos_reg <= POS_LAST, "challenge position out of range")
    `RVC_ASSERT_IMP(a_phase_start, pos_reg == '0, ph_reg == 2'd0, "group phase not aligned")
    `RVC_ASSERT_IMP(a_pop_nonempty, q_pop, cnt_reg != 2'd0, "pop from empty queue")

endmodule

FILE: rtl/core/rc4vc_engine.sv
`include "rc4_variant_challenge_base64_core_macros.svh"

module rc4vc_engine #(
    parameter int KEY_BYTES = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [rc4vc_pkg::KEY_W-1:0]  key,
    input  logic                         q_valid,
    input  rc4vc_pkg::item_t             q_item,
    output logic                         q_pop,
    output logic                         enc_valid,
    output rc4vc_pkg::enc_t              enc,
    input  logic                         enc_ready
);
    import rc4vc_pkg::*;

    localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    eng_state_t       state_reg, state_next;
    logic [7:0]       c_reg;
    kind_t            kind_reg;
    logic [7:0]       a_reg, b_reg, j_reg, i_reg;
    logic [7:0]       sa_reg, sb_reg;
    logic [KIDX_W-1:0] kidx_reg;

    logic [7:0]       perm_mem [256];
    logic [7:0]       rdata_reg;
    logic             mem_we, mem_re;
    logic [7:0]       mem_waddr, mem_wdata, mem_raddr;

    logic [KEY_EXT_W-1:0] key_shift;
    logic [7:0]       kbyte, j_new, a_new, b_new;
    logic [KIDX_W-1:0] kidx_inc;

    // Key byte for the current schedule step
    assign key_shift = KEY_EXT_W'(key) >> {kidx_reg, 3'b000};
    assign kbyte     = key_shift[7:0];
    assign kidx_inc  = (kidx_reg == KIDX_W'(KEY_BYTES - 1)) ? '0 : kidx_reg + 1'b1;

    assign j_new = j_reg + rdata_reg + kbyte;
    assign a_new = a_reg + c_reg + 8'd1;
    assign b_new = b_reg + rdata_reg;

    assign enc.data = c_reg ^ rdata_reg;
    assign enc.kind = kind_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid)
                    state_next = q_item.first ? ST_KS_INIT : ST_RA;
            ST_KS_INIT:
                if (i_reg == 8'hFF)
                    state_next = ST_KS_RI;
            ST_KS_RI: state_next = ST_KS_RJ;
            ST_KS_RJ: state_next = ST_KS_WI;
            ST_KS_WI: state_next = ST_KS_WJ;
            ST_KS_WJ: state_next = (i_reg == 8'hFF) ? ST_RA : ST_KS_RI;
            ST_RA:    state_next = ST_RB;
            ST_RB:    state_next = ST_WA;
            ST_WA:    state_next = ST_WB;
            ST_WB:    state_next = ST_RK;
            ST_RK:    state_next = ST_HAND;
            ST_HAND:
                if (enc_ready)
                    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Memory port and handshake controls
    always_comb
    begin
        q_pop     = 1'b0;
        enc_valid = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = i_reg;
        mem_wdata = i_reg;
        mem_raddr = i_reg;
        unique case (state_reg)
            ST_IDLE:    q_pop = q_valid;
            ST_KS_INIT: mem_we = 1'b1;
            ST_KS_RI:   mem_re = 1'b1;
            ST_KS_RJ:
            begin
                mem_re    = 1'b1;
                mem_raddr = j_new;
            end
            ST_KS_WI:
            begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg;
            end
            ST_KS_WJ:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = sa_reg;
            end
            ST_RA:
            begin
                mem_re    = 1'b1;
                mem_raddr = a_new;
            end
            ST_RB:
            begin
                mem_re    = 1'b1;
                mem_raddr = b_new;
            end
            ST_WA:
            begin
                mem_we    = 1'b1;
                mem_waddr = a_reg;
                mem_wdata = rdata_reg;
            end
            ST_WB:
            begin
                mem_we    = 1'b1;
                mem_waddr = b_reg;
                mem_wdata = sa_reg;
            end
            ST_RK:
            begin
                mem_re    = 1'b1;
                mem_raddr = sa_reg + sb_reg;
            end
            ST_HAND:    enc_valid = 1'b1;
            default:    q_pop = 1'b0;
        endcase
    end

    // Sequencer and index registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            a_reg     <= '0;
            b_reg     <= '0;
            j_reg     <= '0;
            i_reg     <= '0;
            kidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                    if (q_valid && q_item.first)
                    begin
                        a_reg    <= '0;
                        b_reg    <= '0;
                        j_reg    <= '0;
                        i_reg    <= '0;
                        kidx_reg <= '0;
                    end
                ST_KS_INIT: i_reg <= i_reg + 8'd1;
                ST_KS_RJ:   j_reg <= j_new;
                ST_KS_WJ:
                begin
                    i_reg    <= i_reg + 8'd1;
                    kidx_reg <= kidx_inc;
                end
                ST_RA:      a_reg <= a_new;
                ST_RB:      b_reg <= b_new;
                default:    a_reg <= a_reg;
            endcase
        end
    end

    // Datapath holding registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
        begin
            c_reg    <= q_item.data;
            kind_reg <= q_item.kind;
        end
        if (state_reg == ST_KS_RJ || state_reg == ST_RB)
            sa_reg <= rdata_reg;
        if (state_reg == ST_WA)
            sb_reg <= rdata_reg;
    end

    // Permutation memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            perm_mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            rdata_reg <= perm_mem[mem_raddr];
    end

    `RVC_ASSERT_NXT(a_ks_done, state_reg == ST_KS_WJ && i_reg == 8'hFF, state_reg == ST_RA, "key schedule did not hand over to byte step")
    `RVC_ASSERT_IMP(a_port_excl, mem_we, !mem_re, "memory read and write in one cycle")
    `RVC_ASSERT_NXT(a_hand_hold, enc_valid && !enc_ready, enc_valid && $stable(enc.data), "encrypted byte changed while stalled")

endmodule

FILE: rtl/core/rc4vc_b64.sv
`include "rc4_variant_challenge_base64_core_macros.svh"

module rc4vc_b64 (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            enc_valid,
    input  rc4vc_pkg::enc_t                 enc,
    output logic                            enc_ready,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rc4vc_pkg::CHAR_W-1:0]    out_char,
    output logic                            last_char
);
    import rc4vc_pkg::*;

    logic [15:0]       pend_reg;
    logic [CHAR_W-1:0] chr_reg [CHARS_PER_GROUP];
    logic [2:0]        cnt_reg;
    logic              fin_reg;
    logic [5:0]        sx [CHARS_PER_GROUP];
    logic [7:0]        b0, b1;
    logic              take;

    assign enc_ready = (cnt_reg == 3'd0);
    assign take      = enc_valid && enc_ready;
    assign out_valid = (cnt_reg != 3'd0);
    assign out_char  = chr_reg[0];
    assign last_char = fin_reg && (cnt_reg == 3'd1);
    assign b0        = pend_reg[15:8];
    assign b1        = pend_reg[7:0];

    // Sextets of a full or closing group
    always_comb
    begin
        unique case (enc.kind)
            KIND_FINAL:
            begin
                sx[0] = b1[7:2];
                sx[1] = {b1[1:0], enc.data[7:4]};
                sx[2] = {enc.data[3:0], 2'b00};
                sx[3] = 6'd0;
            end
            default:
            begin
                sx[0] = b0[7:2];
                sx[1] = {b0[1:0], b1[7:4]};
                sx[2] = {b1[3:0], enc.data[7:6]};
                sx[3] = enc.data[5:0];
            end
        endcase
    end

    // Character count and pending bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            cnt_reg  <= 3'd0;
            fin_reg  <= 1'b0;
        end
        else if (take)
        begin
            if (enc.kind == KIND_HOLD)
                pend_reg <= {pend_reg[7:0], enc.data};
            else
            begin
                pend_reg <= '0;
                cnt_reg  <= 3'(CHARS_PER_GROUP);
                fin_reg  <= (enc.kind == KIND_FINAL);
            end
        end
        else if (out_valid && out_ready)
            cnt_reg <= cnt_reg - 3'd1;
    end

    // Output character shift register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int k = 0; k < CHARS_PER_GROUP; k++)
                chr_reg[k] <= b64_char(sx[k]);
        end
        else if (out_valid && out_ready)
        begin
            for (int k = 0; k < CHARS_PER_GROUP - 1; k++)
                chr_reg[k] <= chr_reg[k+1];
        end
    end

    `RVC_ASSERT_NXT(a_group_load, take && enc.kind != KIND_HOLD, out_valid && cnt_reg == 3'd4, "group did not load four characters")
    `RVC_ASSERT_NXT(a_final_clear, take && enc.kind == KIND_FINAL, pend_reg == 16'd0, "pending bytes kept after closing group")

endmodule

FILE: rtl/core/rc4_variant_challenge_base64_core.sv
// Channel     | Handshake              | Payload
// ------------+------------------------+----------------------------------
// input       | in_valid / in_ready    | challenge_byte[7:0]
// output      | out_valid / out_ready  | out_char[6:0], last_char
// key config  | key_wr_en (no wait)    | key_wr_data[47:0]
//
// First byte of a challenge: queue pop, table fill, the key schedule steps
// (read S[i], read S[j], write S[i], write S[j]), then the byte step.
// Other bytes: pop, five single-port RAM steps, hand-off.
// Hand-off stalls while the packer still holds characters of the last group.
// Four characters leave per group; a two-entry input queue keeps accepting
// while the packer drains. Reset is asynchronous active low; the key
// returns to "y6E3c9" and the position to the start of a challenge.
module rc4_variant_challenge_base64_core #(
    parameter int KEY_BYTES = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      challenge_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rc4vc_pkg::CHAR_W-1:0]    out_char,
    output logic                            last_char,
    input  logic                            key_wr_en,
    input  logic [rc4vc_pkg::KEY_W-1:0]     key_wr_data
);
    import rc4vc_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic             q_valid, q_pop;
    item_t            q_item;
    logic             enc_valid, enc_ready;
    enc_t             enc;

    // Key register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_reg <= KEY_RESET;
        else if (key_wr_en)
            key_reg <= key_wr_data;
    end

    rc4vc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .challenge_byte (challenge_byte),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    rc4vc_engine #(
        .KEY_BYTES (KEY_BYTES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .enc_valid (enc_valid),
        .enc       (enc),
        .enc_ready (enc_ready)
    );

    rc4vc_b64 u_b64 (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc_valid (enc_valid),
        .enc       (enc),
        .enc_ready (enc_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last_char (last_char)
    );

endmodule

FILE: test/tb_rc4_variant_challenge_base64_core.sv
module tb_rc4_variant_challenge_base64_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rc4vc_pkg::*;

    localparam int KEY_LEN       = 6;
    localparam int IDLE_LIMIT    = 20000;  // cycles with no transaction at all
    localparam int SETTLE_CYCLES = 2000;   // covers a key schedule still running
    localparam int RANDOM_BYTES  = 340;
    localparam int REPORT_MAX    = 10;

    // Expected-character store plus a private copy of the cipher state
    class challenge_scoreboard;
        typedef struct {
            bit [CHAR_W-1:0] ch;
            bit              last;
        } b64_char_t;

        string           alphabet =
            "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        bit [7:0]        perm [256];
        bit [7:0]        idx_a;
        bit [7:0]        idx_b;
        bit [POS_W-1:0]  pos;
        bit [15:0]       held;
        bit [KEY_W-1:0]  key;
        b64_char_t       expected [$];
        int              mismatches;
        int              chars_checked;
        int              bytes_seen;
        int              challenges_done;

        function new();
            key = KEY_RESET;
            idx_a = '0;
            idx_b = '0;
            pos = '0;
            held = '0;
            foreach (perm[i]) perm[i] = '0;
        endfunction

        function void set_key(bit [KEY_W-1:0] k);
            key = k;
        endfunction

        // Standard RC4 key schedule with the current key
        function void run_schedule();
            bit [63:0] kx;
            bit [7:0]  j;
            bit [7:0]  t;
            kx = {16'h0, key};
            j = '0;
            for (int i = 0; i < 256; i++) perm[i] = 8'(i);
            for (int i = 0; i < 256; i++) begin
                j = j + perm[i] + kx[8*(i % KEY_LEN) +: 8];
                t = perm[i];
                perm[i] = perm[j];
                perm[j] = t;
            end
        endfunction

        function void push(bit [5:0] sextet, bit last);
            b64_char_t c;
            bit [7:0]  a;
            a = alphabet[sextet];
            c.ch = a[CHAR_W-1:0];
            c.last = last;
            expected.push_back(c);
        endfunction

        // Accepted challenge byte: encrypt it and queue any characters it closes
        function void note_byte(bit [7:0] c);
            bit [7:0]       t;
            bit [7:0]       sum;
            bit [7:0]       e;
            bit [7:0]       b0;
            bit [7:0]       b1;
            bit [POS_W-1:0] p;
            bytes_seen++;
            if (pos == '0) begin
                run_schedule();
                idx_a = '0;
                idx_b = '0;
                held = '0;
            end
            idx_a = idx_a + c + 8'd1;
            idx_b = idx_b + perm[idx_a];
            t = perm[idx_a];
            perm[idx_a] = perm[idx_b];
            perm[idx_b] = t;
            sum = perm[idx_a] + perm[idx_b];
            e = c ^ perm[sum];

            p = pos;
            pos = (p == POS_LAST) ? '0 : p + 1'b1;

            if (p == POS_LAST) begin
                // short closing group, fourth character fixed with last flag
                b0 = held[7:0];
                push(b0[7:2], 1'b0);
                push({b0[1:0], e[7:4]}, 1'b0);
                push({e[3:0], 2'b00}, 1'b0);
                push(6'd0, 1'b1);
                held = '0;
                challenges_done++;
            end else if (p % 3 == 2) begin
                b0 = held[15:8];
                b1 = held[7:0];
                push(b0[7:2], 1'b0);
                push({b0[1:0], b1[7:4]}, 1'b0);
                push({b1[3:0], e[7:6]}, 1'b0);
                push(e[5:0], 1'b0);
                held = '0;
            end else begin
                held = {held[7:0], e};
            end
        endfunction

        function void check_char(bit [CHAR_W-1:0] ch, bit last);
            b64_char_t x;
            chars_checked++;
            if (expected.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected character %02h last=%0b with nothing pending",
                             ch, last);
                return;
            end
            x = expected.pop_front();
            if (x.ch !== ch || x.last !== last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("character %0d: expected %02h last=%0b, got %02h last=%0b",
                             chars_checked, x.ch, x.last, ch, last);
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [7:0]          challenge_byte;
    logic                out_valid;
    logic                out_ready;
    logic [CHAR_W-1:0]   out_char;
    logic                last_char;
    logic                key_wr_en;
    logic [KEY_W-1:0]    key_wr_data;

    challenge_scoreboard sb = new();
    int                  idle_cycles = 0;
    int                  key_writes = 0;
    bit                  no_idle = 1'b0;

    // Corners first: all-zero, all-one and alternating bytes, single bits
    bit [7:0] directed [20] = '{
        8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h01, 8'h80, 8'h7F, 8'hFE,
        8'h33, 8'hCC, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'hFD, 8'h00
    };

    rc4_variant_challenge_base64_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .challenge_byte (challenge_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_char       (out_char),
        .last_char      (last_char),
        .key_wr_en      (key_wr_en),
        .key_wr_data    (key_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 6);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic int pick_in_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else
            return pick_stall();
    endfunction

    function automatic bit [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'h00;
        else if (r < 20)
            return 8'hFF;
        else
            return 8'($urandom);
    endfunction

    // One input transaction; returns at the falling edge after acceptance
    task automatic send_byte(input bit [7:0] b, input int gap);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        challenge_byte = b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_key(input bit [KEY_W-1:0] k);
        key_wr_en = 1'b1;
        key_wr_data = k;
        @(negedge clk);
        key_wr_en = 1'b0;
        sb.set_key(k);
        key_writes++;
    endtask

    // Wait for all pending characters, then let a running schedule finish
    task automatic settle();
        while (sb.expected.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Output side backpressure
    initial
    begin
        int  hold;
        hold = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (no_idle)
            begin
                out_ready = 1'b1;
                hold = 8;
            end
            else if (out_ready)
            begin
                out_ready = 1'b0;
                hold = pick_stall() - 1;
            end
            else
            begin
                out_ready = 1'b1;
                hold = $urandom_range(0, 11);
            end
        end
    end

    // Monitor: feed the predictor, check results, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_byte(challenge_byte);
            if (out_valid && out_ready)
                sb.check_char(out_char, last_char);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("no transaction for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int              sent;
        int              n;
        int              phase;
        bit [KEY_W-1:0]  k;

        rst_n = 1'b0;
        in_valid = 1'b0;
        challenge_byte = '0;
        key_wr_en = 1'b0;
        key_wr_data = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: one full challenge with the reset key
        foreach (directed[i]) send_byte(directed[i], pick_in_gap());
        // Start of the next one, then change the key in the middle of it
        send_byte(8'hFF, 0);
        send_byte(8'hFF, 0);
        send_byte(8'h00, 0);
        send_byte(8'h00, 0);
        in_valid = 1'b0;
        settle();
        write_key('1);

        // Random phases of random length, key changed between them
        sent = 0;
        phase = 0;
        while (sent < RANDOM_BYTES)
        begin
            n = $urandom_range(15, 60);
            if (n > RANDOM_BYTES - sent)
                n = RANDOM_BYTES - sent;
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (n) send_byte(pick_byte(), pick_in_gap());
            sent += n;
            in_valid = 1'b0;
            no_idle = 1'b0;
            settle();
            case (phase % 5)
                0: k = '0;
                1: k = KEY_W'({$urandom, $urandom});
                2: k = KEY_RESET;
                3: k = '1;
                default: k = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
            endcase
            write_key(k);
            phase++;
        end

        settle();
        if (sb.expected.size() != 0)
        begin
            sb.mismatches++;
            $display("%0d characters never arrived", sb.expected.size());
        end

        $display("Sent %0d challenge bytes (%0d full challenges), checked %0d characters",
                 sb.bytes_seen, sb.challenges_done, sb.chars_checked);
        $display("Key register written %0d times incl. all-zero, all-one and reset keys",
                 key_writes);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: rc4_variant_challenge_base64_core.f
+incdir+rtl/core
rtl/core/rc4vc_pkg.sv
rtl/core/rc4vc_front.sv
rtl/core/rc4vc_engine.sv
rtl/core/rc4vc_b64.sv
rtl/core/rc4_variant_challenge_base64_core.sv
test/tb_rc4_variant_challenge_base64_core.sv
